@@ design/cmpf_pkg.sv @@
// Shared definitions for the circle-mode paint filter: register codes,
// constants, and the command/status types between controller and datapath.
// No dependencies.
package cmpf_pkg;

    localparam int DEF_MAX_WIDTH   = 256;
    localparam int DEF_MAX_HEIGHT  = 256;
    localparam int DEF_MAX_SAMPLES = 200;
    localparam int DEF_NUM_BINS    = 256;
    localparam int DEF_MAX_RADIUS  = 32;

    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH   = 3'd0,
        REG_HEIGHT  = 3'd1,
        REG_RADIUS  = 3'd2,
        REG_SAMPLES = 3'd3,
        REG_SMOOTH  = 3'd4,
        REG_CHROMA  = 3'd5
    } cfg_reg_t;

    localparam logic [8:0] RST_WIDTH   = 9'd256;
    localparam logic [8:0] RST_HEIGHT  = 9'd256;
    localparam logic [5:0] RST_RADIUS  = 6'd4;
    localparam logic [7:0] RST_SAMPLES = 8'd4;
    localparam logic [7:0] RST_SMOOTH  = 8'd8;
    localparam logic       RST_CHROMA  = 1'b1;

    localparam int         ROUND_BIAS     = 127;
    localparam int         FULL_SCALE     = 255;
    localparam int         RECIP_SCALE    = 257;
    localparam int         RECIP_SHIFT    = 16;
    localparam int         LUMA_MIN_COUNT = 15;
    localparam logic [7:0] NEUTRAL_CHROMA = 8'd128;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_START,
        OP_CENTER,
        OP_GEN_INIT,
        OP_GEN_STEP,
        OP_PICK_INIT,
        OP_PICK_STEP,
        OP_TBL_SET,
        OP_CLR_STEP,
        OP_SAMP_INIT,
        OP_SAMP_STEP,
        OP_SCAN_INIT,
        OP_SCAN_STEP,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_OUT_LOAD
    } cmpf_op_t;

    typedef struct packed {
        cmpf_op_t op;
    } cmpf_cmd_t;

    typedef struct packed {
        logic table_valid;
        logic gen_done;
        logic pick_done;
        logic clr_last;
        logic samp_done;
        logic scan_last;
        logic div_done;
    } cmpf_stat_t;

endpackage

@@ design/circle_mode_paint_filter_unit.sv @@
// Circle-mode paint filter: oil-paint mode filter over a stored YCbCr frame.
// Input channel (in_valid/in_ready) carries load or compute items; a load
// writes one pixel into the frame store, a compute filters one coordinate.
// Output channel (out_valid/out_ready) carries one filtered pixel per compute.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
// registers; cfg_ready is always high, write only while the block is idle.
// Loads may follow back to back. A compute's sample loop is paced by the
// frame-store and histogram-memory read latencies, and its tail by the shared
// bit-serial divider. The first compute after reset or a register write also
// rebuilds the circle table.
// One item is worked on at a time; in_ready is high only while idle.
// Reset restores register defaults and marks the offset table stale; frame
// contents are undefined until loaded. A stalled receiver holds the result
// in the output register; a new item is taken meanwhile, and its result
// waits until the previous transfer completes.
module circle_mode_paint_filter_unit
    import cmpf_pkg::*;
#(
    parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
    parameter int NUM_BINS    = DEF_NUM_BINS,
    parameter int MAX_RADIUS  = DEF_MAX_RADIUS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  mode,
    input  logic [7:0]            x_coord,
    input  logic [7:0]            y_coord,
    input  logic [7:0]            luma_in,
    input  logic [7:0]            cb_in,
    input  logic [7:0]            cr_in,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            luma_out,
    output logic [7:0]            cb_out,
    output logic [7:0]            cr_out
);

    cmpf_cmd_t  cmd;
    cmpf_stat_t stat;

    assign cfg_ready = 1'b1;

    cmpf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    cmpf_dp #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .MAX_SAMPLES (MAX_SAMPLES),
        .NUM_BINS    (NUM_BINS),
        .MAX_RADIUS  (MAX_RADIUS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .x_coord   (x_coord),
        .y_coord   (y_coord),
        .luma_in   (luma_in),
        .cb_in     (cb_in),
        .cr_in     (cr_in),
        .luma_out  (luma_out),
        .cb_out    (cb_out),
        .cr_out    (cr_out)
    );

endmodule

@@ design/cmpf_ctrl.sv @@
// Controller for the circle-mode paint filter: sequences table build,
// histogram clear, sampling, peak scan, division and result transfer.
// Depends on cmpf_pkg.
module cmpf_ctrl
    import cmpf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       mode,
    output logic       out_valid,
    input  logic       out_ready,
    input  cmpf_stat_t stat,
    output cmpf_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CTR,
        S_GEN_INIT,
        S_GEN,
        S_PICK_INIT,
        S_PICK,
        S_CLR,
        S_SAMP_INIT,
        S_SAMP,
        S_SCAN_INIT,
        S_SCAN,
        S_DIV_INIT,
        S_DIV,
        S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (mode)
                    begin
                        cmd.op     = OP_START;
                        state_next = S_CTR;
                    end
                    else
                    begin
                        cmd.op = OP_LOAD;
                    end
                end
            end
            S_CTR:
            begin
                cmd.op     = OP_CENTER;
                state_next = stat.table_valid ? S_CLR : S_GEN_INIT;
            end
            S_GEN_INIT:
            begin
                cmd.op     = OP_GEN_INIT;
                state_next = S_GEN;
            end
            S_GEN:
            begin
                cmd.op = OP_GEN_STEP;
                if (stat.gen_done)
                    state_next = S_PICK_INIT;
            end
            S_PICK_INIT:
            begin
                cmd.op     = OP_PICK_INIT;
                state_next = S_PICK;
            end
            S_PICK:
            begin
                if (stat.pick_done)
                begin
                    cmd.op     = OP_TBL_SET;
                    state_next = S_CLR;
                end
                else
                begin
                    cmd.op = OP_PICK_STEP;
                end
            end
            S_CLR:
            begin
                cmd.op = OP_CLR_STEP;
                if (stat.clr_last)
                    state_next = S_SAMP_INIT;
            end
            S_SAMP_INIT:
            begin
                cmd.op     = OP_SAMP_INIT;
                state_next = S_SAMP;
            end
            S_SAMP:
            begin
                if (stat.samp_done)
                    state_next = S_SCAN_INIT;
                else
                    cmd.op = OP_SAMP_STEP;
            end
            S_SCAN_INIT:
            begin
                cmd.op     = OP_SCAN_INIT;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.op = OP_SCAN_STEP;
                if (stat.scan_last)
                    state_next = S_DIV_INIT;
            end
            S_DIV_INIT:
            begin
                cmd.op     = OP_DIV_INIT;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (stat.div_done)
                    state_next = S_FIN;
                else
                    cmd.op = OP_DIV_STEP;
            end
            S_FIN:
            begin
                // hold the result until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = OP_OUT_LOAD;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ design/cmpf_dp.sv @@
// Datapath for the circle-mode paint filter: configuration registers,
// frame store, circle offset tables, histogram memory and shared divider.
// Depends on cmpf_pkg.
module cmpf_dp
    import cmpf_pkg::*;
#(
    parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
    parameter int NUM_BINS    = DEF_NUM_BINS,
    parameter int MAX_RADIUS  = DEF_MAX_RADIUS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmpf_cmd_t             cmd,
    output cmpf_stat_t            stat,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [7:0]            x_coord,
    input  logic [7:0]            y_coord,
    input  logic [7:0]            luma_in,
    input  logic [7:0]            cb_in,
    input  logic [7:0]            cr_in,
    output logic [7:0]            luma_out,
    output logic [7:0]            cb_out,
    output logic [7:0]            cr_out
);

    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW          = $clog2(STORE_DEPTH);
    localparam int MAX_DIM     = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int CLW         = $clog2(MAX_DIM + MAX_RADIUS + 256) + 1;
    localparam int RW          = $clog2(MAX_RADIUS + 1);
    localparam int OW          = RW + 1;
    localparam int EW          = RW + 4;
    localparam int CAND_MAX    = 8 * (MAX_RADIUS + 2);
    localparam int CNW         = $clog2(CAND_MAX + 1);
    localparam int CIW         = $clog2(CAND_MAX);
    localparam int DW          = $clog2(MAX_SAMPLES + 1);
    localparam int SIW         = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int REMW        = $clog2(MAX_SAMPLES + CAND_MAX + 1);
    localparam int BW          = $clog2(NUM_BINS);
    localparam int CNTW        = DW;
    localparam int SUMW        = CNTW + 8;
    localparam int VW          = 8 + BW + 1;
    localparam int PRW         = VW + 9;
    localparam int BINW        = CNTW + 3 * SUMW;
    localparam int KW          = $clog2(SUMW + 1);
    localparam logic [1:0] SEL_LUMA = 2'd0;
    localparam logic [1:0] SEL_CB   = 2'd1;
    localparam logic [1:0] SEL_CR   = 2'd2;

    typedef enum logic [2:0] {
        SM_OFS,
        SM_ADDR,
        SM_PIX,
        SM_BIN,
        SM_UPD
    } smp_stage_t;

    // configuration
    logic [8:0] fw_reg, fh_reg;
    logic [5:0] rad_reg;
    logic [7:0] scnt_reg, smooth_reg;
    logic       chroma_reg, tvalid_reg;

    logic signed [CLW-1:0] w_m1, h_m1;
    logic [RW-1:0]         r_eff;
    logic [DW-1:0]         depth;
    logic [BW-1:0]         sm;

    always_comb
    begin
        if (fw_reg == '0)
            w_m1 = '0;
        else if (int'(fw_reg) > MAX_WIDTH)
            w_m1 = CLW'(MAX_WIDTH - 1);
        else
            w_m1 = CLW'(fw_reg) - CLW'(1);
        if (fh_reg == '0)
            h_m1 = '0;
        else if (int'(fh_reg) > MAX_HEIGHT)
            h_m1 = CLW'(MAX_HEIGHT - 1);
        else
            h_m1 = CLW'(fh_reg) - CLW'(1);
        if (int'(rad_reg) < 2)
            r_eff = RW'(2);
        else if (int'(rad_reg) > MAX_RADIUS)
            r_eff = RW'(MAX_RADIUS);
        else
            r_eff = RW'(rad_reg);
        depth = (int'(scnt_reg) > MAX_SAMPLES) ? DW'(MAX_SAMPLES) : DW'(scnt_reg);
        sm    = (int'(smooth_reg) > NUM_BINS - 1) ? BW'(NUM_BINS - 1) : BW'(smooth_reg);
    end

    // memories
    logic [23:0]         store_mem [STORE_DEPTH];
    logic [2*OW-1:0]     cand_mem  [CAND_MAX];
    logic [2*OW-1:0]     otab_mem  [MAX_SAMPLES];
    logic [BINW-1:0]     bin_mem   [NUM_BINS];

    logic [23:0]     frame_q;
    logic [2*OW-1:0] cand_q, otab_q;
    logic [BINW-1:0] bin_q;

    // control counters
    logic [RW:0]          g_x, g_y, g_y1, g_x1;
    logic signed [EW-1:0] g_err, g_e1, g_e_next;
    logic [2:0]           g_j;
    logic [CNW-1:0]       g_n;
    logic                 gen_done, g_step_dn;
    logic [DW-1:0]        pk_i;
    logic [CNW-1:0]       pk_q;
    logic [CNW-1:0]       pk_ca;
    logic [REMW-1:0]      pk_rem;
    logic                 pk_stage;
    logic [BW-1:0]        clr_b;
    logic [DW-1:0]        smp_i;
    smp_stage_t           smp_stage;
    logic [BW-1:0]        sc_b;
    logic [1:0]           dv_sel;
    logic [KW-1:0]        dv_k;
    logic                 dv_done;

    // data registers
    logic signed [CLW-1:0] cx_reg, cy_reg;
    logic [23:0]           ctr_pix, pix_reg;
    logic [VW-1:0]         v_reg;
    logic [BW-1:0]         bin_idx_reg;
    logic [CNTW-1:0]       best_cnt;
    logic [SUMW-1:0]       best_l, best_cb, best_cr;
    logic [SUMW-1:0]       dv_num;
    logic [CNTW-1:0]       dv_rem;
    logic [7:0]            q_l, q_cb, q_cr;
    logic [7:0]            luma_reg, cb_reg, cr_reg;

    assign luma_out = luma_reg;
    assign cb_out   = cb_reg;
    assign cr_out   = cr_reg;

    // pick index past the last candidate reads the last candidate
    assign pk_ca = (pk_q >= g_n) ? (g_n - 1'b1) : pk_q;

    // center clamp and load address
    logic signed [CLW-1:0] x_in, y_in, x_cl, y_cl;
    logic [AW-1:0]         ctr_addr, load_addr;
    logic                  load_ok;

    always_comb
    begin
        x_in      = CLW'(x_coord);
        y_in      = CLW'(y_coord);
        x_cl      = (x_in > w_m1) ? w_m1 : x_in;
        y_cl      = (y_in > h_m1) ? h_m1 : y_in;
        ctr_addr  = AW'(32'(y_cl) * 32'(MAX_WIDTH) + 32'(x_cl));
        load_addr = AW'(32'(y_coord) * 32'(MAX_WIDTH) + 32'(x_coord));
        load_ok   = (int'(x_coord) < MAX_WIDTH) && (int'(y_coord) < MAX_HEIGHT);
    end

    // midpoint circle point for the current octant
    logic signed [OW-1:0] gxs, gys, pt_dx, pt_dy;

    always_comb
    begin
        gxs = OW'(g_x);
        gys = OW'(g_y);
        unique case (g_j)
            3'd0: begin pt_dx =  gxs; pt_dy =  gys; end
            3'd1: begin pt_dx =  gys; pt_dy =  gxs; end
            3'd2: begin pt_dx = -gys; pt_dy =  gxs; end
            3'd3: begin pt_dx = -gxs; pt_dy =  gys; end
            3'd4: begin pt_dx = -gxs; pt_dy = -gys; end
            3'd5: begin pt_dx = -gys; pt_dy = -gxs; end
            3'd6: begin pt_dx =  gys; pt_dy = -gxs; end
            3'd7: begin pt_dx =  gxs; pt_dy = -gys; end
            default: begin pt_dx = '0; pt_dy = '0; end
        endcase
        gen_done  = (g_y > g_x);
        g_step_dn = (g_j == 3'd7);
        g_y1      = g_y + 1'b1;
        g_e1      = g_err + EW'(1) + (EW'(g_y1) <<< 1);
        g_x1      = g_x;
        g_e_next  = g_e1;
        if (g_e1 >= $signed(EW'(g_x)))
        begin
            g_x1     = g_x - 1'b1;
            g_e_next = g_e1 + EW'(1) - (EW'(g_x - 1'b1) <<< 1);
        end
    end

    // sample address from the current offset
    logic signed [OW-1:0]  o_dx, o_dy;
    logic signed [CLW-1:0] sx_raw, sy_raw, sx_c, sy_c;
    logic [AW-1:0]         smp_addr;

    always_comb
    begin
        o_dx     = otab_q[2*OW-1:OW];
        o_dy     = otab_q[OW-1:0];
        sx_raw   = cx_reg + CLW'(o_dx);
        sy_raw   = cy_reg + CLW'(o_dy);
        sx_c     = (sx_raw < 0) ? '0 : ((sx_raw > w_m1) ? w_m1 : sx_raw);
        sy_c     = (sy_raw < 0) ? '0 : ((sy_raw > h_m1) ? h_m1 : sy_raw);
        smp_addr = AW'(32'(sy_c) * 32'(MAX_WIDTH) + 32'(sx_c));
    end

    // bin = (luma * sm + 127) / 255 by reciprocal and one correction
    logic [PRW-1:0] recip_prod;
    logic [BW:0]    q0;
    logic [VW-1:0]  q0_rem;
    logic [BW-1:0]  bin_idx;

    always_comb
    begin
        recip_prod = PRW'(v_reg) * PRW'(RECIP_SCALE);
        q0         = (BW+1)'(recip_prod >> RECIP_SHIFT);
        q0_rem     = v_reg - VW'(q0) * VW'(FULL_SCALE);
        if (q0_rem >= VW'(FULL_SCALE))
            bin_idx = BW'(q0 + 1'b1);
        else
            bin_idx = BW'(q0);
    end

    // bin word fields
    logic [CNTW-1:0] bq_cnt;
    logic [SUMW-1:0] bq_l, bq_cb, bq_cr;

    assign bq_cnt = bin_q[BINW-1 -: CNTW];
    assign bq_l   = bin_q[3*SUMW-1 -: SUMW];
    assign bq_cb  = bin_q[2*SUMW-1 -: SUMW];
    assign bq_cr  = bin_q[SUMW-1:0];

    // divider step
    logic [CNTW:0]   dv_trial;
    logic [CNTW-1:0] dv_rem_next;
    logic            dv_bit;
    logic [SUMW-1:0] dv_next_src;

    always_comb
    begin
        dv_trial = {dv_rem, dv_num[SUMW-1]};
        if (dv_trial >= {1'b0, best_cnt})
        begin
            dv_bit      = 1'b1;
            dv_rem_next = CNTW'(dv_trial - {1'b0, best_cnt});
        end
        else
        begin
            dv_bit      = 1'b0;
            dv_rem_next = CNTW'(dv_trial);
        end
        dv_next_src = (dv_sel == SEL_LUMA) ? best_cb : best_cr;
    end

    // memory enables
    logic            store_re, cand_we, cand_re, otab_we, otab_re, bin_re, bin_we;
    logic [AW-1:0]   store_ra;
    logic [BW-1:0]   bin_ra, bin_wa;
    logic [BINW-1:0] bin_wd;

    always_comb
    begin
        store_re = 1'b0;
        store_ra = ctr_addr;
        cand_we  = 1'b0;
        cand_re  = 1'b0;
        otab_we  = 1'b0;
        otab_re  = 1'b0;
        bin_re   = 1'b0;
        bin_ra   = bin_idx;
        bin_we   = 1'b0;
        bin_wa   = clr_b;
        bin_wd   = '0;
        unique case (cmd.op)
            OP_START:
            begin
                store_re = 1'b1;
            end
            OP_GEN_STEP:
            begin
                cand_we = !gen_done && (int'(g_n) < CAND_MAX);
            end
            OP_PICK_STEP:
            begin
                cand_re = !pk_stage && (pk_rem < REMW'(depth));
                otab_we = pk_stage;
            end
            OP_CLR_STEP:
            begin
                bin_we = 1'b1;
            end
            OP_SAMP_STEP:
            begin
                unique case (smp_stage)
                    SM_OFS:  otab_re = (smp_i != depth);
                    SM_ADDR:
                    begin
                        store_re = 1'b1;
                        store_ra = smp_addr;
                    end
                    SM_PIX:  ;
                    SM_BIN:  bin_re = 1'b1;
                    SM_UPD:
                    begin
                        bin_we = 1'b1;
                        bin_wa = bin_idx_reg;
                        bin_wd = {bq_cnt + 1'b1,
                                  bq_l + SUMW'(pix_reg[23:16]),
                                  bq_cb + SUMW'(pix_reg[15:8]),
                                  bq_cr + SUMW'(pix_reg[7:0])};
                    end
                    default: ;
                endcase
            end
            OP_SCAN_INIT:
            begin
                bin_re = 1'b1;
                bin_ra = '0;
            end
            OP_SCAN_STEP:
            begin
                bin_re = (sc_b != sm);
                bin_ra = sc_b + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD && load_ok)
            store_mem[load_addr] <= {luma_in, cb_in, cr_in};
        if (store_re)
            frame_q <= store_mem[store_ra];
    end

    always_ff @(posedge clk)
    begin
        if (cand_we)
            cand_mem[g_n[CIW-1:0]] <= {pt_dx, pt_dy};
        if (cand_re)
            cand_q <= cand_mem[pk_ca[CIW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (otab_we)
            otab_mem[pk_i[SIW-1:0]] <= cand_q;
        if (otab_re)
            otab_q <= otab_mem[smp_i[SIW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (bin_we)
            bin_mem[bin_wa] <= bin_wd;
        if (bin_re)
            bin_q <= bin_mem[bin_ra];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg     <= RST_WIDTH;
            fh_reg     <= RST_HEIGHT;
            rad_reg    <= RST_RADIUS;
            scnt_reg   <= RST_SAMPLES;
            smooth_reg <= RST_SMOOTH;
            chroma_reg <= RST_CHROMA;
            tvalid_reg <= 1'b0;
            g_x        <= '0;
            g_y        <= '0;
            g_err      <= '0;
            g_j        <= '0;
            g_n        <= '0;
            pk_i       <= '0;
            pk_q       <= '0;
            pk_rem     <= '0;
            pk_stage   <= 1'b0;
            clr_b      <= '0;
            smp_i      <= '0;
            smp_stage  <= SM_OFS;
            sc_b       <= '0;
            dv_sel     <= SEL_LUMA;
            dv_k       <= '0;
            dv_done    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_WIDTH:   begin fw_reg     <= cfg_data;      tvalid_reg <= 1'b0; end
                    REG_HEIGHT:  begin fh_reg     <= cfg_data;      tvalid_reg <= 1'b0; end
                    REG_RADIUS:  begin rad_reg    <= cfg_data[5:0]; tvalid_reg <= 1'b0; end
                    REG_SAMPLES: begin scnt_reg   <= cfg_data[7:0]; tvalid_reg <= 1'b0; end
                    REG_SMOOTH:  begin smooth_reg <= cfg_data[7:0]; tvalid_reg <= 1'b0; end
                    REG_CHROMA:  begin chroma_reg <= cfg_data[0];   tvalid_reg <= 1'b0; end
                    default: ;
                endcase
            end
            unique case (cmd.op)
                OP_CENTER:
                begin
                    clr_b <= '0;
                end
                OP_GEN_INIT:
                begin
                    g_x   <= (RW+1)'(r_eff);
                    g_y   <= '0;
                    g_err <= '0;
                    g_j   <= '0;
                    g_n   <= '0;
                end
                OP_GEN_STEP:
                begin
                    if (!gen_done)
                    begin
                        if (int'(g_n) < CAND_MAX)
                            g_n <= g_n + 1'b1;
                        g_j <= g_j + 1'b1;
                        // advance the octant point after all eight mirrors
                        if (g_step_dn)
                        begin
                            g_y   <= g_y1;
                            g_x   <= g_x1;
                            g_err <= g_e_next;
                        end
                    end
                end
                OP_PICK_INIT:
                begin
                    pk_i     <= '0;
                    pk_q     <= '0;
                    pk_rem   <= REMW'(depth >> 1);
                    pk_stage <= 1'b0;
                end
                OP_PICK_STEP:
                begin
                    if (!pk_stage)
                    begin
                        // reduce the running remainder one step at a time
                        if (pk_rem >= REMW'(depth))
                        begin
                            pk_rem <= pk_rem - REMW'(depth);
                            pk_q   <= pk_q + 1'b1;
                        end
                        else
                        begin
                            pk_stage <= 1'b1;
                        end
                    end
                    else
                    begin
                        pk_i     <= pk_i + 1'b1;
                        pk_rem   <= pk_rem + REMW'(g_n);
                        pk_stage <= 1'b0;
                    end
                end
                OP_TBL_SET:
                begin
                    tvalid_reg <= 1'b1;
                end
                OP_CLR_STEP:
                begin
                    clr_b <= clr_b + 1'b1;
                end
                OP_SAMP_INIT:
                begin
                    smp_i     <= '0;
                    smp_stage <= SM_OFS;
                end
                OP_SAMP_STEP:
                begin
                    unique case (smp_stage)
                        SM_OFS:
                        begin
                            if (smp_i != depth)
                                smp_stage <= SM_ADDR;
                        end
                        SM_ADDR: smp_stage <= SM_PIX;
                        SM_PIX:  smp_stage <= SM_BIN;
                        SM_BIN:  smp_stage <= SM_UPD;
                        SM_UPD:
                        begin
                            smp_i     <= smp_i + 1'b1;
                            smp_stage <= SM_OFS;
                        end
                        default: smp_stage <= SM_OFS;
                    endcase
                end
                OP_SCAN_INIT:
                begin
                    sc_b <= '0;
                end
                OP_SCAN_STEP:
                begin
                    if (sc_b != sm)
                        sc_b <= sc_b + 1'b1;
                end
                OP_DIV_INIT:
                begin
                    dv_sel  <= SEL_LUMA;
                    dv_k    <= '0;
                    dv_done <= 1'b0;
                end
                OP_DIV_STEP:
                begin
                    if (dv_k != KW'(SUMW))
                        dv_k <= dv_k + 1'b1;
                    else if (dv_sel == SEL_CR)
                        dv_done <= 1'b1;
                    else
                    begin
                        dv_sel <= dv_sel + 1'b1;
                        dv_k   <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_START:
            begin
                cx_reg <= x_cl;
                cy_reg <= y_cl;
            end
            OP_CENTER:
            begin
                ctr_pix <= frame_q;
            end
            OP_SAMP_STEP:
            begin
                if (smp_stage == SM_PIX)
                begin
                    v_reg   <= VW'(frame_q[23:16]) * VW'(sm) + VW'(ROUND_BIAS);
                    pix_reg <= frame_q;
                end
                if (smp_stage == SM_BIN)
                    bin_idx_reg <= bin_idx;
            end
            OP_SCAN_STEP:
            begin
                // keep the first bin with the largest count
                if (sc_b == '0 || bq_cnt > best_cnt)
                begin
                    best_cnt <= bq_cnt;
                    best_l   <= bq_l;
                    best_cb  <= bq_cb;
                    best_cr  <= bq_cr;
                end
            end
            OP_DIV_INIT:
            begin
                dv_num <= best_l;
                dv_rem <= '0;
            end
            OP_DIV_STEP:
            begin
                if (dv_k != KW'(SUMW))
                begin
                    dv_num <= {dv_num[SUMW-2:0], dv_bit};
                    dv_rem <= dv_rem_next;
                end
                else if (!dv_done)
                begin
                    unique case (dv_sel)
                        SEL_LUMA: q_l  <= dv_num[7:0];
                        SEL_CB:   q_cb <= dv_num[7:0];
                        SEL_CR:   q_cr <= dv_num[7:0];
                        default: ;
                    endcase
                    dv_num <= dv_next_src;
                    dv_rem <= '0;
                end
            end
            OP_OUT_LOAD:
            begin
                if (chroma_reg)
                begin
                    if (best_cnt != '0)
                    begin
                        luma_reg <= q_l;
                        cb_reg   <= q_cb;
                        cr_reg   <= q_cr;
                    end
                    else
                    begin
                        luma_reg <= ctr_pix[23:16];
                        cb_reg   <= ctr_pix[15:8];
                        cr_reg   <= ctr_pix[7:0];
                    end
                end
                else
                begin
                    luma_reg <= (int'(best_cnt) > LUMA_MIN_COUNT) ? q_l : ctr_pix[23:16];
                    cb_reg   <= NEUTRAL_CHROMA;
                    cr_reg   <= NEUTRAL_CHROMA;
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        stat.table_valid = tvalid_reg;
        stat.gen_done    = gen_done;
        stat.pick_done   = (pk_i == depth) && !pk_stage;
        stat.clr_last    = (clr_b == sm);
        stat.samp_done   = (smp_stage == SM_OFS) && (smp_i == depth);
        stat.scan_last   = (sc_b == sm);
        stat.div_done    = dv_done;
    end

endmodule

@@ design/cmpf_check.sv @@
// Port-level checks for the circle-mode paint filter, bound to the top level.
// Depends on cmpf_pkg.
module cmpf_check
    import cmpf_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  cfg_ready,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  mode,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [7:0]            luma_out,
    input logic [7:0]            cb_out,
    input logic [7:0]            cr_out
);

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(luma_out) && $stable(cb_out) && $stable(cr_out))
        else $error("result payload changed while stalled");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before transfer");

    // a load never produces a result on its own
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !mode && !out_valid |=> !out_valid)
        else $error("result appeared after a load");

    // a compute occupies the block
    a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && mode |=> !in_ready && !out_valid || !in_ready)
        else $error("input taken during a compute");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("configuration port not ready");

endmodule

bind circle_mode_paint_filter_unit cmpf_check u_cmpf_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_ready (cfg_ready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .luma_out  (luma_out),
    .cb_out    (cb_out),
    .cr_out    (cr_out)
);

@@ tb/tb.sv @@
// Testbench for circle_mode_paint_filter_unit: drives loads, computes and
// register writes, predicts every filtered pixel and checks it in order.
// Depends on cmpf_pkg and the unit under test only.
`timescale 1ns / 100ps

module tb;
    import cmpf_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int WATCHDOG_MAX  = 20000;
    localparam int SETTLE_CYCLES = 20;
    localparam int LONG_HOLD     = 400;
    localparam int WIN           = 16;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_B = 3'd7;

    typedef enum logic {MODE_LOAD = 1'b0, MODE_COMPUTE = 1'b1} item_mode_t;

    typedef struct {
        item_mode_t mode;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] luma;
        logic [7:0] cb;
        logic [7:0] cr;
    } pixel_item_t;

    typedef struct {
        logic [7:0] luma;
        logic [7:0] cb;
        logic [7:0] cr;
    } pixel_t;

    class paint_scoreboard;
        logic [7:0] luma_mem [65536];
        logic [7:0] cb_mem [65536];
        logic [7:0] cr_mem [65536];
        bit         loaded [65536];
        int         fw, fh, rad, samp, smooth;
        bit         chroma_on;
        int         circ_dx [DEF_MAX_SAMPLES];
        int         circ_dy [DEF_MAX_SAMPLES];
        bit         circ_ok;
        pixel_t     pixel_q [$];
        int         errors;

        function new();
            fw = RST_WIDTH; fh = RST_HEIGHT; rad = RST_RADIUS;
            samp = RST_SAMPLES; smooth = RST_SMOOTH; chroma_on = RST_CHROMA;
            circ_ok = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_WIDTH:   fw = int'(data);
                REG_HEIGHT:  fh = int'(data);
                REG_RADIUS:  rad = int'(data[5:0]);
                REG_SAMPLES: samp = int'(data[7:0]);
                REG_SMOOTH:  smooth = int'(data[7:0]);
                REG_CHROMA:  chroma_on = data[0];
                default:     return;
            endcase
            circ_ok = 0;
        endfunction

        function int taps();
            return samp > DEF_MAX_SAMPLES ? DEF_MAX_SAMPLES : samp;
        endfunction

        function int eff_w();
            return fw < 1 ? 1 : (fw > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : fw);
        endfunction

        function int eff_h();
            return fh < 1 ? 1 : (fh > DEF_MAX_HEIGHT ? DEF_MAX_HEIGHT : fh);
        endfunction

        function int clip(int v, int lo, int hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        // Midpoint circle, eight octants per step, then evenly spaced picks.
        function void build_circle();
            int cx [8*(DEF_MAX_RADIUS+2)];
            int cy [8*(DEF_MAX_RADIUS+2)];
            int n, r, px, py, err, d, k;
            n = 0;
            r = clip(rad, 2, DEF_MAX_RADIUS);
            px = r; py = 0; err = 0;
            d = taps();
            while (px >= py) begin
                int ox [8];
                int oy [8];
                ox = '{px, py, -py, -px, -px, -py, py, px};
                oy = '{py, px, px, py, -py, -px, -px, -py};
                for (int j = 0; j < 8; j++) begin
                    if (n < 8*(DEF_MAX_RADIUS+2)) begin
                        cx[n] = ox[j]; cy[n] = oy[j]; n++;
                    end
                end
                py++;
                err += 1 + 2*py;
                if (2*(err - px) + 1 > 0) begin
                    px--;
                    err += 1 - 2*px;
                end
            end
            for (int i = 0; i < d; i++) begin
                k = (i*n + d/2) / d;
                if (k >= n) k = n - 1;
                circ_dx[i] = cx[k];
                circ_dy[i] = cy[k];
            end
            circ_ok = 1;
        endfunction

        // True when every pixel a compute at (x, y) would read has been loaded.
        function bit reads_loaded(int x, int y);
            int w, h, cxp, cyp;
            if (!circ_ok) build_circle();
            w = eff_w(); h = eff_h();
            cxp = clip(x, 0, w-1); cyp = clip(y, 0, h-1);
            if (!loaded[cyp*256 + cxp]) return 0;
            for (int i = 0; i < taps(); i++)
                if (!loaded[clip(cyp + circ_dy[i], 0, h-1)*256 + clip(cxp + circ_dx[i], 0, w-1)])
                    return 0;
            return 1;
        endfunction

        function void note_item(pixel_item_t it);
            int unsigned cnt [256];
            int unsigned ysum [256];
            int unsigned bsum [256];
            int unsigned rsum [256];
            int w, h, cxp, cyp, a, c, peak;
            int unsigned sm, b, pc;
            pixel_t p;
            if (it.mode == MODE_LOAD) begin
                a = it.y*256 + it.x;
                luma_mem[a] = it.luma; cb_mem[a] = it.cb; cr_mem[a] = it.cr;
                loaded[a] = 1;
                return;
            end
            if (!circ_ok) build_circle();
            w = eff_w(); h = eff_h();
            sm = smooth;
            cxp = clip(it.x, 0, w-1); cyp = clip(it.y, 0, h-1);
            for (int i = 0; i <= sm; i++) begin
                cnt[i] = 0; ysum[i] = 0; bsum[i] = 0; rsum[i] = 0;
            end
            for (int i = 0; i < taps(); i++) begin
                a = clip(cyp + circ_dy[i], 0, h-1)*256 + clip(cxp + circ_dx[i], 0, w-1);
                b = (luma_mem[a]*sm + 127) / 255;
                cnt[b]++;
                ysum[b] += luma_mem[a]; bsum[b] += cb_mem[a]; rsum[b] += cr_mem[a];
            end
            peak = 0;
            for (int i = 1; i <= sm; i++)
                if (cnt[i] > cnt[peak]) peak = i;
            pc = cnt[peak];
            c = cyp*256 + cxp;
            if (chroma_on) begin
                if (pc > 0) begin
                    p.luma = 8'(ysum[peak] / pc);
                    p.cb   = 8'(bsum[peak] / pc);
                    p.cr   = 8'(rsum[peak] / pc);
                end else begin
                    p.luma = luma_mem[c]; p.cb = cb_mem[c]; p.cr = cr_mem[c];
                end
            end else begin
                p.luma = pc > LUMA_MIN_COUNT ? 8'(ysum[peak] / pc) : luma_mem[c];
                p.cb = NEUTRAL_CHROMA;
                p.cr = NEUTRAL_CHROMA;
            end
            pixel_q.push_back(p);
        endfunction

        function void check_result(logic [7:0] luma, logic [7:0] cb, logic [7:0] cr);
            pixel_t p;
            if (pixel_q.size() == 0) begin
                $error("unexpected result luma=%0d cb=%0d cr=%0d", luma, cb, cr);
                errors++;
                return;
            end
            p = pixel_q.pop_front();
            if (luma !== p.luma) begin
                $error("luma_out expected %0d actual %0d", p.luma, luma); errors++;
            end
            if (cb !== p.cb) begin
                $error("cb_out expected %0d actual %0d", p.cb, cb); errors++;
            end
            if (cr !== p.cr) begin
                $error("cr_out expected %0d actual %0d", p.cr, cr); errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic                  mode;
    logic [7:0]            x_coord;
    logic [7:0]            y_coord;
    logic [7:0]            luma_in;
    logic [7:0]            cb_in;
    logic [7:0]            cr_in;
    logic                  out_valid;
    logic                  out_ready;
    logic [7:0]            luma_out;
    logic [7:0]            cb_out;
    logic [7:0]            cr_out;

    paint_scoreboard sb;
    bit              no_idle;
    int              hold_seq = 0;
    int              quiet_cycles = 0;

    circle_mode_paint_filter_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .x_coord   (x_coord),
        .y_coord   (y_coord),
        .luma_in   (luma_in),
        .cb_in     (cb_in),
        .cr_in     (cr_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .luma_out  (luma_out),
        .cb_out    (cb_out),
        .cr_out    (cr_out)
    );

    always #(CLK_HALF) clk = ~clk;

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 3);
    endfunction

    // Receiver: one draw per result; a hold request stalls it for a long stretch.
    initial
    begin
        int hold;
        int seen;
        hold = 0;
        seen = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                sb.check_result(luma_out, cb_out, cr_out);
                hold = draw_gap();
            end
            if (hold_seq != seen)
            begin
                hold = LONG_HOLD;
                seen = hold_seq;
            end
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                hold--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_MAX)
        begin
            $display("tb: errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic push(pixel_item_t it);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        mode     <= it.mode;
        x_coord  <= it.x;
        y_coord  <= it.y;
        luma_in  <= it.luma;
        cb_in    <= it.cb;
        cr_in    <= it.cr;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        sb.note_item(it);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
    endtask

    // Hold the sender until every result is back, then let loads settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pixel_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic pixel_item_t make_load(bit anywhere);
        pixel_item_t it;
        it.mode = MODE_LOAD;
        it.x    = anywhere ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, WIN-1));
        it.y    = anywhere ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, WIN-1));
        it.luma = 8'($urandom_range(0, 255));
        it.cb   = 8'($urandom_range(0, 255));
        it.cr   = 8'($urandom_range(0, 255));
        return it;
    endfunction

    // Compute only where every read pixel is loaded; otherwise fill the window.
    function automatic pixel_item_t make_item();
        pixel_item_t it;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5) return make_load(1);
        if (pick < 40) return make_load(0);
        it = make_load(0);
        it.mode = MODE_COMPUTE;
        for (int t = 0; t < 8; t++)
        begin
            it.x = $urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(0, WIN-1));
            it.y = $urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(0, WIN-1));
            if (sb.reads_loaded(it.x, it.y)) return it;
        end
        return make_load(0);
    endfunction

    task automatic run_phase(int w, int h, int r, int s, int sm, int ce,
                             int n, bit quiet, bit squeeze, bit spare);
        if (spare)
        begin
            write_reg(IDX_SPARE_A, CFG_DATA_W'($urandom_range(0, 511)));
            write_reg(IDX_SPARE_B, CFG_DATA_W'($urandom_range(0, 511)));
        end
        write_reg(REG_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_HEIGHT, CFG_DATA_W'(h));
        write_reg(REG_RADIUS, CFG_DATA_W'(r));
        write_reg(REG_SAMPLES, CFG_DATA_W'(s));
        write_reg(REG_SMOOTH, CFG_DATA_W'(sm));
        write_reg(REG_CHROMA, CFG_DATA_W'(ce));
        cfg_valid <= 1'b0;
        @(posedge clk);
        no_idle = quiet;
        if (squeeze)
            hold_seq++;
        for (int i = 0; i < n; i++)
            push(make_item());
        drain();
    endtask

    initial
    begin
        pixel_item_t it;
        sb = new();
        clk = 0; rst_n = 0;
        cfg_valid = 0; cfg_index = '0; cfg_data = '0;
        in_valid = 0; mode = 0; x_coord = 0; y_coord = 0;
        luma_in = 0; cb_in = 0; cr_in = 0;
        no_idle = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extreme loads at the corners, then the window's first row.
        it = '{MODE_LOAD, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
        push(it);
        it = '{MODE_LOAD, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
        push(it);
        it = '{MODE_LOAD, 8'd255, 8'd0, 8'd170, 8'd85, 8'd170};
        push(it);
        it = '{MODE_LOAD, 8'd0, 8'd255, 8'd85, 8'd170, 8'd85};
        push(it);
        for (int i = 0; i < 8; i++)
        begin
            it = make_load(0);
            it.y = 8'd0;
            it.x = 8'(i);
            push(it);
        end
        it = '{MODE_COMPUTE, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255};
        if (sb.reads_loaded(0, 0)) push(it);
        for (int i = 0; i < 80; i++)
            push(make_item());
        drain();

        run_phase(16, 16, 32, 200, 255, 1, 95, 0, 0, 1);
        run_phase(1, 1, 2, 0, 0, 1, 95, 0, 0, 0);
        run_phase(256, 256, 2, 255, 0, 0, 95, 1, 0, 0);
        run_phase(12, 256, 63, 20, 1, 0, 95, 0, 0, 0);
        run_phase(0, 511, 0, 1, 255, 1, 95, 0, 0, 0);
        run_phase(9, 5, 7, 33, 3, 0, 95, 0, 0, 0);
        run_phase(256, 1, 3, 17, 0, 0, 95, 0, 0, 0);
        run_phase(16, 14, 5, 12, 8, 1, 95, 0, 1, 0);

        if (sb.errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
